@@ design/assert_macros.svh @@
// Assertion macros for the checker file of the sequence store.
// No dependencies. Each macro expects signals clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define ISU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only outside reset.
`define ISU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/isu_pkg.sv @@
// Shared types, codes and sizing helpers for the indexed sequence store.
// No dependencies; used by every module of the block.
package isu_pkg;

  localparam int CAPACITY_DEF   = 256;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    ACT_READ   = 2'd0,
    ACT_WRITE  = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_ERASE  = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Broadcast to every cell of the row; all flags are already qualified
  // by the input transaction.
  typedef struct packed {
    logic load;
    logic wr;
    logic ins;
    logic ers;
    logic rd;
  } cell_ctrl_t;

  // Power-of-two group size whose square covers the capacity, so that the
  // two read reduction levels stay of similar size.
  function automatic int group_size(input int cap);
    int lg;
    lg = $clog2(cap);
    return 1 << ((lg + 1) >> 1);
  endfunction

endpackage

@@ design/indexed_sequence_insert_erase_unit.sv @@
// Indexed sequence store with read, write, insert and erase.
// Input channel in_*: action, position and value; one transaction per request.
// Result channel out_*: read_value, length and status; exactly one result
// per request, delivered in request order.
// Each element lives in a cell of a row; insert shifts every cell above the
// position and erase every cell at or above it in the same cycle, so the state
// is updated at the edge that accepts the request.
// Throughput: one request per cycle while out_ready holds. A result passes
// the group register of the read reduction, which feeds the cross-group OR,
// and then the output register, where out_valid rises.
// A stalled result holds in the output register; one more request may enter
// the reduction stage behind it, after which in_ready falls until out_ready.
// Reset (rst_n low, synchronous) empties the sequence and drops any pending
// results. No clearing pass is needed: cells at or above the length are never
// read. Out-of-range positions and inserts into a full store leave the state
// unchanged and report a status code with read_value zero.
module indexed_sequence_insert_erase_unit import isu_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_action,
  input  logic [$clog2(CAPACITY+1)-1:0]  in_position,
  input  logic [DATA_WIDTH-1:0]          in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [DATA_WIDTH-1:0]          out_read_value,
  output logic [$clog2(CAPACITY+1)-1:0]  out_length,
  output logic [1:0]                     out_status
);

  localparam int POS_W      = $clog2(CAPACITY + 1);
  localparam int GROUP_SIZE = group_size(CAPACITY);
  localparam int GROUPS     = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam logic [POS_W-1:0] CAP_P = POS_W'(CAPACITY);

  logic                  in_fire, a_fire;
  act_t                  act;
  cell_ctrl_t            ctrl;
  status_t               status_nxt;
  logic                  pos_lt;
  logic [POS_W-1:0]      count_r, count_nxt, len_req;
  logic                  a_valid_r, a_valid_nxt;
  logic [POS_W-1:0]      a_len_r;
  status_t               a_status_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_rv_r, rv_nxt;
  logic [POS_W-1:0]      out_len_r;
  status_t               out_status_r;
  logic [DATA_WIDTH-1:0] grp_q [GROUPS];

  assign a_fire   = a_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !a_valid_r || a_fire;
  assign in_fire  = in_valid && in_ready;

  assign act    = act_t'(in_action);
  assign pos_lt = (in_position < count_r);

  always_comb begin
    ctrl       = '0;
    ctrl.load  = in_fire;
    status_nxt = ST_DONE;
    len_req    = count_r;
    unique case (act)
      ACT_READ: begin
        if (pos_lt) ctrl.rd = in_fire;
        else        status_nxt = ST_RANGE;
      end
      ACT_WRITE: begin
        if (pos_lt) ctrl.wr = in_fire;
        else        status_nxt = ST_RANGE;
      end
      ACT_INSERT: begin
        if (in_position > count_r) begin
          status_nxt = ST_RANGE;
        end else if (count_r == CAP_P) begin
          status_nxt = ST_FULL;
        end else begin
          ctrl.ins = in_fire;
          len_req  = count_r + 1'b1;
        end
      end
      ACT_ERASE: begin
        if (pos_lt) begin
          ctrl.ers = in_fire;
          len_req  = count_r - 1'b1;
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      default: status_nxt = ST_RANGE;
    endcase
    count_nxt = in_fire ? len_req : count_r;
  end

  isu_row #(
    .DATA_WIDTH(DATA_WIDTH),
    .CAPACITY  (CAPACITY),
    .POS_W     (POS_W),
    .GROUP_SIZE(GROUP_SIZE),
    .GROUPS    (GROUPS)
  ) u_row (
    .clk  (clk),
    .ctrl (ctrl),
    .pos  (in_position),
    .value(in_value),
    .grp_q(grp_q)
  );

  // Second reduction level across the group results.
  always_comb begin
    rv_nxt = '0;
    for (int g = 0; g < GROUPS; g++) begin
      rv_nxt = rv_nxt | grp_q[g];
    end
  end

  assign a_valid_nxt   = in_fire ? 1'b1 : (a_fire ? 1'b0 : a_valid_r);
  assign out_valid_nxt = a_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_len_r    <= len_req;
      a_status_r <= status_nxt;
    end
    if (a_fire) begin
      out_rv_r     <= rv_nxt;
      out_len_r    <= a_len_r;
      out_status_r <= a_status_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_rv_r;
  assign out_length     = out_len_r;
  assign out_status     = out_status_r;

endmodule

@@ design/isu_cell.sv @@
// One storage cell of the sequence row: holds one element and shifts it
// to or from its neighbours on insert and erase. Depends on isu_pkg.
module isu_cell import isu_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int POS_W      = 9,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [POS_W-1:0]      pos,
  input  logic [DATA_WIDTH-1:0] value,
  input  logic [DATA_WIDTH-1:0] left_q,
  input  logic [DATA_WIDTH-1:0] right_q,
  output logic [DATA_WIDTH-1:0] q,
  output logic [DATA_WIDTH-1:0] rd_data
);

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

  logic [DATA_WIDTH-1:0] data_r, data_nxt;
  logic                  at_pos, above_pos;

  assign at_pos    = (pos == MY_IDX);
  assign above_pos = (MY_IDX > pos);

  always_comb begin
    data_nxt = data_r;
    if (ctrl.wr && at_pos) begin
      data_nxt = value;
    end else if (ctrl.ins) begin
      if (above_pos) begin
        data_nxt = left_q;
      end else if (at_pos) begin
        data_nxt = value;
      end
    end else if (ctrl.ers && (above_pos || at_pos)) begin
      data_nxt = right_q;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q       = data_r;
  assign rd_data = (ctrl.rd && at_pos) ? data_r : '0;

endmodule

@@ design/isu_row.sv @@
// Row of storage cells plus the first level of the read reduction, which
// registers one partial result per group of cells. Depends on isu_pkg, isu_cell.
module isu_row import isu_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int POS_W      = 9,
  parameter int GROUP_SIZE = 16,
  parameter int GROUPS     = 16
) (
  input  logic                  clk,
  input  cell_ctrl_t            ctrl,
  input  logic [POS_W-1:0]      pos,
  input  logic [DATA_WIDTH-1:0] value,
  output logic [DATA_WIDTH-1:0] grp_q [GROUPS]
);

  localparam int SLOTS = GROUPS * GROUP_SIZE;

  logic [DATA_WIDTH-1:0] q_w    [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_w   [SLOTS];
  logic [DATA_WIDTH-1:0] grp_r  [GROUPS];
  logic [DATA_WIDTH-1:0] grp_nxt[GROUPS];

  for (genvar i = 0; i < SLOTS; i++) begin : g_slot
    if (i < CAPACITY) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w, right_w;
      if (i == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = q_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = q_w[i+1];
      end
      isu_cell #(
        .DATA_WIDTH(DATA_WIDTH),
        .POS_W     (POS_W),
        .IDX       (i)
      ) u_cell (
        .clk    (clk),
        .ctrl   (ctrl),
        .pos    (pos),
        .value  (value),
        .left_q (left_w),
        .right_q(right_w),
        .q      (q_w[i]),
        .rd_data(rd_w[i])
      );
    end else begin : g_pad
      assign rd_w[i] = '0;
    end
  end

  // At most one cell drives a non-zero read word, so OR acts as the select.
  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        grp_nxt[g] = grp_nxt[g] | rd_w[g*GROUP_SIZE + k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      grp_r <= grp_nxt;
    end
  end

  assign grp_q = grp_r;

endmodule

@@ design/isu_checker.sv @@
// Port-level checks on the result channel of the sequence store, bound to
// the top level. Depends on isu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module isu_checker import isu_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [DATA_WIDTH-1:0]         out_read_value,
  input logic [$clog2(CAPACITY+1)-1:0] out_length,
  input logic [1:0]                    out_status
);

  localparam int POS_W = $clog2(CAPACITY + 1);
  localparam logic [POS_W-1:0] CAP_P = POS_W'(CAPACITY);

  // A stalled result transaction must hold its payload.
  `ISU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_read_value) && $stable(out_length) && $stable(out_status),
    "result changed while stalled")

  `ISU_ASSERT_SAME(a_len_bound, out_valid, out_length <= CAP_P,
    "reported length exceeds capacity")

  `ISU_ASSERT_SAME(a_full_len, out_valid && (out_status == ST_FULL),
    out_length == CAP_P, "store full reported below capacity")

  `ISU_ASSERT_SAME(a_err_zero, out_valid && (out_status != ST_DONE),
    out_read_value == '0, "failed request returned a non-zero value")

endmodule

bind indexed_sequence_insert_erase_unit isu_checker #(
  .CAPACITY  (CAPACITY),
  .DATA_WIDTH(DATA_WIDTH)
) u_isu_checker (.*);
